// ===== design/msq_pkg.sv =====
// msq_pkg: shared constants of the melody note sequencer
// widths of the note table, index, timer and tempo, item mode and register codes
// no dependencies

package msq_pkg;

	// note table geometry
	localparam int MAX_NOTES = 256;
	localparam int ADDR_W    = $clog2(MAX_NOTES);
	localparam int COUNT_W   = $clog2(MAX_NOTES + 1);
	localparam int IDX_W     = COUNT_W + 1;

	// field widths
	localparam int FREQ_W  = 16;
	localparam int MS_W    = 16;
	localparam int TEMPO_W = 16;
	localparam int TIME_W  = 24;
	localparam int PROD_W  = MS_W + TEMPO_W;
	localparam int TEMPO_FRAC_BITS = 8;

	localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};
	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 16'd256;

	// item modes
	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_REWIND = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_TEMPO  = 2'd0;
	localparam logic [1:0] REG_REPEAT = 2'd1;
	localparam logic [1:0] REG_ZIGZAG = 2'd2;

	// one table entry as stored
	typedef struct packed {
		logic [MS_W-1:0]   ms;
		logic [FREQ_W-1:0] freq;
	} note_entry_t;

	// one result
	typedef struct packed {
		logic               table_full;
		logic [COUNT_W-1:0] table_count;
		logic               playing;
		logic               silence;
		logic [TIME_W-1:0]  tone_time;
		logic [FREQ_W-1:0]  tone_freq;
		logic               note_start;
	} result_t;

endpackage

// ===== design/melody_note_sequencer_core.sv =====
// melody_note_sequencer_core: buzzer melody sequencer with a note table in block memory
// depends on msq_pkg
//
// Usage:
//   s_axis carries one item per transaction: tuser is the mode (append, clear,
//   millisecond tick, rewind), tdata holds the appended note's frequency and
//   duration. m_axis returns exactly one result per item: note start with its
//   frequency and tempo-scaled duration, silence, playing, note count, full flag.
//   cfg_we / cfg_index / cfg_data write tempo_scale, repeat_on and zigzag_on;
//   write only while the block is idle.
// Processing:
//   append, clear, rewind and ticks that start no note write their result into the
//   output register in the cycle after acceptance. A tick that starts a note goes
//   through the synchronous table read, the duration multiply, then forming the
//   result and stepping the index; no new item is taken until its result is formed.
// Reset:
//   arst_n clears the count, index and timer, sets forward direction, loads tempo 1.0;
//   the note table itself is not cleared, entries are read only below the count.
// Stall:
//   a result waits in the output register while m_axis_tready is low; the next
//   item is taken in the same cycle the waiting result is taken.

module melody_note_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // note_freq[15:0], note_ms[31:16]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // note_start[0], tone_freq[16:1], tone_time[40:17],
	                                   // silence[41], playing[42], table_count[51:43],
	                                   // table_full[52], zero[55:53]
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;

	localparam int RES_W = $bits(msq_pkg::result_t);

	// state and configuration registers
	logic [1:0]                        state_q;
	logic [msq_pkg::COUNT_W-1:0]       count_q;
	logic signed [msq_pkg::IDX_W-1:0]  index_q;
	logic                              forward_q;
	logic [msq_pkg::TIME_W-1:0]        elapsed_q;
	logic [msq_pkg::TIME_W-1:0]        cur_time_q;
	logic [msq_pkg::TEMPO_W-1:0]       tempo_q;
	logic                              repeat_q;
	logic                              zigzag_q;

	// output register
	logic                              out_valid_q;
	msq_pkg::result_t                  out_q;

	// note table and its registered read port
	msq_pkg::note_entry_t              note_mem [msq_pkg::MAX_NOTES];
	msq_pkg::note_entry_t              rd_data_s1;
	logic [msq_pkg::PROD_W-1:0]        prod_s2;
	logic [msq_pkg::FREQ_W-1:0]        freq_s2;

	// input decode
	logic                              in_fire;
	logic [1:0]                        mode;
	msq_pkg::note_entry_t              in_entry;
	logic [msq_pkg::TIME_W-1:0]        elapsed_inc;
	logic                              tick_due;
	logic signed [msq_pkg::IDX_W-1:0]  count_sx;
	logic                              index_ok;
	logic                              table_has_room;
	logic                              mem_we;
	logic                              mem_re;

	// index stepping and duration result
	logic signed [msq_pkg::IDX_W-1:0]  index_step;
	logic signed [msq_pkg::IDX_W-1:0]  index_next;
	logic                              forward_next;
	logic [msq_pkg::TIME_W-1:0]        scaled_time;
	msq_pkg::result_t                  res_direct;
	msq_pkg::result_t                  res_note;

	assign mode     = s_axis_tuser;
	assign in_entry = '{ms: s_axis_tdata[31:16], freq: s_axis_tdata[15:0]};

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// timer and range checks for a tick
	assign elapsed_inc    = (elapsed_q == msq_pkg::TIME_MAX) ? elapsed_q
	                        : elapsed_q + msq_pkg::TIME_W'(1);
	assign tick_due       = elapsed_inc > cur_time_q;
	assign count_sx       = $signed({1'b0, count_q});
	assign index_ok       = !index_q[msq_pkg::IDX_W-1] && (index_q < count_sx);
	assign table_has_room = count_q < msq_pkg::COUNT_W'(msq_pkg::MAX_NOTES);

	assign mem_we = in_fire && (mode == msq_pkg::MODE_APPEND) && table_has_room;
	assign mem_re = in_fire && (mode == msq_pkg::MODE_TICK) && tick_due && index_ok;

	// note table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			note_mem[count_q[msq_pkg::ADDR_W-1:0]] <= in_entry;
		end
		if (mem_re) begin
			rd_data_s1 <= note_mem[index_q[msq_pkg::ADDR_W-1:0]];
		end
	end

	// duration scaling multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			prod_s2 <= msq_pkg::PROD_W'(rd_data_s1.ms) * msq_pkg::PROD_W'(tempo_q);
			freq_s2 <= rd_data_s1.freq;
		end
	end

	// drop the fraction of the Q24.8 product (ms times Q8.8 tempo); its integer part fits the timer width
	always_comb begin
		if ((prod_s2 >> (msq_pkg::TEMPO_FRAC_BITS + msq_pkg::TIME_W)) != '0) begin
			scaled_time = msq_pkg::TIME_MAX;
		end else begin
			scaled_time = prod_s2[msq_pkg::TEMPO_FRAC_BITS +: msq_pkg::TIME_W];
		end
	end

	// index step with wrap or zigzag turn at the table ends when repeat is on
	always_comb begin
		index_step   = forward_q ? index_q + msq_pkg::IDX_W'(1) : index_q - msq_pkg::IDX_W'(1);
		index_next   = index_step;
		forward_next = forward_q;
		if (repeat_q && (index_step >= count_sx)) begin
			if (zigzag_q) begin
				index_next   = count_sx - msq_pkg::IDX_W'(2);
				forward_next = !forward_q;
			end else begin
				index_next = '0;
			end
		end else if (repeat_q && index_step[msq_pkg::IDX_W-1]) begin
			if (zigzag_q) begin
				index_next   = msq_pkg::IDX_W'(1);
				forward_next = !forward_q;
			end else begin
				index_next = count_sx - msq_pkg::IDX_W'(1);
			end
		end
	end

	// result of an item finished in the accept cycle
	always_comb begin
		res_direct             = '0;
		res_direct.playing     = 1'b1;
		res_direct.table_count = count_q;
		case (mode)
			msq_pkg::MODE_APPEND: begin
				if (table_has_room) begin
					res_direct.table_count = count_q + msq_pkg::COUNT_W'(1);
				end else begin
					res_direct.table_full = 1'b1;
				end
			end
			msq_pkg::MODE_CLEAR: begin
				res_direct.table_count = '0;
			end
			msq_pkg::MODE_TICK: begin
				res_direct.playing = !tick_due;
			end
			msq_pkg::MODE_REWIND: begin
				res_direct.silence = 1'b1;
			end
			default: begin
				res_direct.playing = 1'b1;
			end
		endcase
	end

	// result of a tick that starts a note
	always_comb begin
		res_note             = '0;
		res_note.note_start  = 1'b1;
		res_note.tone_freq   = freq_s2;
		res_note.tone_time   = scaled_time;
		res_note.playing     = 1'b1;
		res_note.table_count = count_q;
	end

	// sequencer control, state update and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			index_q     <= '0;
			forward_q   <= 1'b1;
			elapsed_q   <= '0;
			cur_time_q  <= '0;
			tempo_q     <= msq_pkg::TEMPO_RESET;
			repeat_q    <= 1'b0;
			zigzag_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					msq_pkg::REG_TEMPO:  tempo_q  <= cfg_data;
					msq_pkg::REG_REPEAT: repeat_q <= cfg_data[0];
					msq_pkg::REG_ZIGZAG: zigzag_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (mode)
							msq_pkg::MODE_APPEND: begin
								if (table_has_room) begin
									count_q <= count_q + msq_pkg::COUNT_W'(1);
								end
							end
							msq_pkg::MODE_CLEAR: begin
								count_q    <= '0;
								index_q    <= '0;
								forward_q  <= 1'b1;
								elapsed_q  <= '0;
								cur_time_q <= '0;
							end
							msq_pkg::MODE_TICK: begin
								elapsed_q <= elapsed_inc;
							end
							msq_pkg::MODE_REWIND: begin
								index_q <= '0;
							end
							default: ;
						endcase
						if (mem_re) begin
							state_q <= ST_READ;
						end else begin
							out_q       <= res_direct;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					out_q       <= res_note;
					out_valid_q <= 1'b1;
					cur_time_q  <= scaled_time;
					elapsed_q   <= '0;
					index_q     <= index_next;
					forward_q   <= forward_next;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(56 - RES_W)'(0), out_q};

endmodule

// ===== tb/tb_melody_note_sequencer_core.sv =====
`timescale 1ns / 1ps
// tb_melody_note_sequencer_core: self-checking bench for the melody note sequencer core
// runs append, clear, tick and rewind transactions under several tempo and repeat settings
// depends on msq_pkg and melody_note_sequencer_core

module tb_melody_note_sequencer_core;
	import msq_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 115;

	// expected-result tracker: mirrors the note table, index, direction and timer
	class melody_scoreboard;
		note_entry_t        notes [MAX_NOTES];
		logic [COUNT_W-1:0] count;
		int                 idx;
		bit                 fwd;
		logic [TIME_W-1:0]  elapsed;
		logic [TIME_W-1:0]  cur_time;
		logic [TEMPO_W-1:0] tempo;
		bit                 rep;
		bit                 zig;
		result_t            awaited_results [$];
		int                 errors;

		function new();
			count    = '0;
			idx      = 0;
			fwd      = 1'b1;
			elapsed  = '0;
			cur_time = '0;
			tempo    = TEMPO_RESET;
			rep      = 1'b0;
			zig      = 1'b0;
			errors   = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [15:0] value);
			case (index)
				REG_TEMPO:  tempo = value;
				REG_REPEAT: rep = value[0];
				REG_ZIGZAG: zig = value[0];
				default: ;
			endcase
		endfunction

		// move to the next note, wrapping or turning at the table ends
		function void step_index();
			int n;
			n = int'(count);
			idx = fwd ? idx + 1 : idx - 1;
			if (rep && idx >= n) begin
				if (zig) begin
					idx = n - 2;
					fwd = !fwd;
				end else begin
					idx = 0;
				end
			end else if (rep && idx < 0) begin
				if (zig) begin
					idx = 1;
					fwd = !fwd;
				end else begin
					idx = n - 1;
				end
			end
		endfunction

		// work out the result of one accepted item and queue it
		function void log_item(logic [1:0] mode, logic [FREQ_W-1:0] note_freq,
		                       logic [MS_W-1:0] note_ms);
			result_t           r;
			logic [PROD_W-1:0] scaled;
			r = '0;
			r.playing = 1'b1;
			case (mode)
				MODE_APPEND: begin
					if (int'(count) < MAX_NOTES) begin
						notes[count[ADDR_W-1:0]].freq = note_freq;
						notes[count[ADDR_W-1:0]].ms   = note_ms;
						count = count + 1'b1;
					end else begin
						r.table_full = 1'b1;
					end
				end
				MODE_CLEAR: begin
					count    = '0;
					idx      = 0;
					fwd      = 1'b1;
					elapsed  = '0;
					cur_time = '0;
				end
				MODE_TICK: begin
					if (elapsed != TIME_MAX)
						elapsed = elapsed + 1'b1;
					if (elapsed > cur_time) begin
						if (idx < 0 || idx >= int'(count)) begin
							r.playing = 1'b0;
						end else begin
							scaled = (PROD_W'(notes[idx].ms) * PROD_W'(tempo)) >> TEMPO_FRAC_BITS;
							if (scaled > PROD_W'(TIME_MAX))
								scaled = PROD_W'(TIME_MAX);
							r.note_start = 1'b1;
							r.tone_freq  = notes[idx].freq;
							r.tone_time  = scaled[TIME_W-1:0];
							cur_time     = scaled[TIME_W-1:0];
							elapsed      = '0;
							step_index();
						end
					end
				end
				default: begin
					idx       = 0;
					r.silence = 1'b1;
				end
			endcase
			r.table_count = count;
			awaited_results.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [55:0] data);
			result_t want;
			result_t got;
			got = result_t'(data[52:0]);
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual 0x%0h", $time, data);
				return;
			end
			want = awaited_results.pop_front();
			check_field("note_start", 32'(want.note_start), 32'(got.note_start));
			check_field("tone_freq", 32'(want.tone_freq), 32'(got.tone_freq));
			check_field("tone_time", 32'(want.tone_time), 32'(got.tone_time));
			check_field("silence", 32'(want.silence), 32'(got.silence));
			check_field("playing", 32'(want.playing), 32'(got.playing));
			check_field("table_count", 32'(want.table_count), 32'(got.table_count));
			check_field("table_full", 32'(want.table_full), 32'(got.table_full));
			check_field("pad bits", 32'd0, 32'(data[55:53]));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // note_freq[15:0], note_ms[31:16]
	logic [1:0]  s_axis_tuser;   // mode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;   // note_start, tone_freq, tone_time, silence, playing,
	                             // table_count, table_full, zero pad
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	melody_scoreboard board = new();
	int cycle_count = 0;
	int hold = 0;
	int refill = 0;
	bit no_idle = 1'b0;

	melody_note_sequencer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// run-time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: take transactions, then stall a random number of cycles
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
				board.check_result(m_axis_tdata);
				hold = no_idle ? 0 : $urandom_range(0, 7);
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// one input transaction, after a random gap
	task automatic send_item(input logic [1:0] mode, input logic [FREQ_W-1:0] freq,
	                         input logic [MS_W-1:0] ms);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {ms, freq};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		board.log_item(mode, freq, ms);
	endtask

	// wait until every queued result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(index, value);
	endtask

	// short durations keep notes turning over; now and then a full-range one
	function automatic logic [MS_W-1:0] pick_ms();
		if ($urandom_range(0, 15) == 0)
			return MS_W'($urandom);
		if (board.tempo > 16'd1024)
			return '0;
		return MS_W'($urandom_range(0, 3));
	endfunction

	// mostly ticks over a live table, with appends, rewinds and clears mixed in
	task automatic send_random_item();
		int pick;
		if (refill > 0) begin
			refill--;
			send_item(MODE_APPEND, FREQ_W'($urandom), pick_ms());
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				send_item(MODE_TICK, FREQ_W'($urandom), MS_W'($urandom));
			end else if (pick < 84) begin
				send_item(MODE_APPEND, FREQ_W'($urandom), pick_ms());
			end else if (pick < 94) begin
				send_item(MODE_REWIND, FREQ_W'($urandom), MS_W'($urandom));
			end else begin
				send_item(MODE_CLEAR, FREQ_W'($urandom), MS_W'($urandom));
				refill = $urandom_range(1, 5);
			end
		end
	endtask

	// new settings, a fresh table of first_notes notes, then random traffic
	task automatic run_phase(input logic [15:0] tempo, input bit rep, input bit zig,
	                         input int first_notes, input int n_items, input bit calm);
		drain();
		write_reg(REG_TEMPO, tempo);
		write_reg(REG_REPEAT, 16'(rep));
		write_reg(REG_ZIGZAG, 16'(zig));
		no_idle = calm;
		refill  = 0;
		send_item(MODE_CLEAR, FREQ_W'($urandom), MS_W'($urandom));
		repeat (first_notes) send_item(MODE_APPEND, FREQ_W'($urandom), pick_ms());
		repeat (2) send_item(MODE_TICK, FREQ_W'($urandom), MS_W'($urandom));
		repeat (n_items) send_random_item();
	endtask

	// main sequence
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_APPEND;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_TEMPO;
		cfg_data      <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, field extremes, not-due ticks, index past the end
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_REWIND, 16'hFFFF, 16'hFFFF);
		send_item(MODE_APPEND, 16'h0000, 16'h0000);
		send_item(MODE_APPEND, 16'hFFFF, 16'hFFFF);
		send_item(MODE_APPEND, 16'hA5A5, 16'h0001);
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_REWIND, 16'h0000, 16'h0000);
		send_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_APPEND, 16'h5A5A, 16'h0002);
		repeat (4) send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_REWIND, 16'h0000, 16'h0000);
		send_item(MODE_TICK, 16'h0000, 16'h0000);
		send_item(MODE_CLEAR, 16'h0000, 16'h0000);

		// random phases across tempo and repeat settings
		run_phase(16'd0, 1'b1, 1'b0, 3, PHASE_ITEMS, 1'b0);
		run_phase(16'd0, 1'b1, 1'b1, 1, PHASE_ITEMS, 1'b1);
		run_phase(16'hFFFF, 1'b1, 1'b1, 4, PHASE_ITEMS, 1'b0);
		run_phase(16'd1, 1'b0, 1'b1, 2, PHASE_ITEMS, 1'b1);
		run_phase(16'($urandom_range(0, 700)), 1'b1, 1'b0, 5, PHASE_ITEMS, 1'b0);
		// fill the table past its end so appends get dropped
		run_phase(16'd128, 1'b1, 1'b1, MAX_NOTES + 4, 60, 1'b0);
		run_phase(TEMPO_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 3,
		          PHASE_ITEMS, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/msq_pkg.sv
design/melody_note_sequencer_core.sv
tb/tb_melody_note_sequencer_core.sv
